FILE: design/info_frame_receiver_defines.svh
// ----------------------------------------------------------------------------
// info_frame_receiver_defines.svh
// Assertion macros used by the info frame receiver parser.
// ----------------------------------------------------------------------------
`ifndef INFO_FRAME_RECEIVER_DEFINES_SVH
`define INFO_FRAME_RECEIVER_DEFINES_SVH

// Same-cycle implication, disabled while reset is held.
`define IFR_ASSERT_NOW(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("info_frame_receiver: same-cycle check failed");

// Next-cycle implication, disabled while reset is held.
`define IFR_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("info_frame_receiver: next-cycle check failed");

`endif

FILE: design/ifr_pkg.sv
// ----------------------------------------------------------------------------
// ifr_pkg
// Types and constants of the info frame receiver.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package ifr_pkg;

  localparam int unsigned CfgIdxW = 3;

  // Configuration register indexes.
  localparam logic [CfgIdxW-1:0] CFG_FLAG      = 3'd0;
  localparam logic [CfgIdxW-1:0] CFG_ADDRESS   = 3'd1;
  localparam logic [CfgIdxW-1:0] CFG_ESCAPE    = 3'd2;
  localparam logic [CfgIdxW-1:0] CFG_STUFFMASK = 3'd3;
  localparam logic [CfgIdxW-1:0] CFG_CTRLSEQ0  = 3'd4;
  localparam logic [CfgIdxW-1:0] CFG_CTRLSEQ1  = 3'd5;

  // Register values after reset.
  localparam logic [7:0] RST_FLAG      = 8'h7E;
  localparam logic [7:0] RST_ADDRESS   = 8'h03;
  localparam logic [7:0] RST_ESCAPE    = 8'h7D;
  localparam logic [7:0] RST_STUFFMASK = 8'h20;
  localparam logic [7:0] RST_CTRLSEQ0  = 8'h00;
  localparam logic [7:0] RST_CTRLSEQ1  = 8'h40;

  // Result kinds.
  localparam logic [1:0] KIND_PAYLOAD = 2'd0;
  localparam logic [1:0] KIND_STATUS  = 2'd1;
  localparam logic [1:0] KIND_REJECT  = 2'd2;

  // Frame status codes.
  localparam logic [1:0] ST_ACCEPTED  = 2'd0;
  localparam logic [1:0] ST_CHECK_ERR = 2'd1;
  localparam logic [1:0] ST_DUPLICATE = 2'd2;

  // Reply codes.
  localparam logic [1:0] REPLY_NONE   = 2'd0;
  localparam logic [1:0] REPLY_READY  = 2'd1;
  localparam logic [1:0] REPLY_REJECT = 2'd2;

  typedef struct packed {
    logic [7:0] flag_byte;
    logic [7:0] address_byte;
    logic [7:0] escape_byte;
    logic [7:0] stuff_mask;
    logic [7:0] ctrl_seq0;
    logic [7:0] ctrl_seq1;
  } cfg_t;

  typedef struct packed {
    logic [7:0] rx_byte;
  } in_item_t;

  typedef struct packed {
    logic [1:0] out_kind;
    logic [7:0] payload_byte;
    logic [1:0] frame_status;
    logic [1:0] reply_kind;
    logic       reply_seq;
  } res_t;

endpackage

`default_nettype wire

FILE: design/ifr_stream_if.sv
// ----------------------------------------------------------------------------
// ifr_stream_if
// Valid/ready request channel carrying one payload struct.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface ifr_stream_if #(
  parameter type payload_t = logic [7:0]
);
  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

`default_nettype wire

FILE: design/ifr_cfg_regs.sv
// ----------------------------------------------------------------------------
// ifr_cfg_regs
// Configuration register file written through a plain write port.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module ifr_cfg_regs (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         cfg_we,
  input  wire logic [ifr_pkg::CfgIdxW-1:0]  cfg_index,
  input  wire logic [7:0]                   cfg_wdata,
  output ifr_pkg::cfg_t                     cfg_o
);

  ifr_pkg::cfg_t cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.flag_byte    <= ifr_pkg::RST_FLAG;
      cfg_r.address_byte <= ifr_pkg::RST_ADDRESS;
      cfg_r.escape_byte  <= ifr_pkg::RST_ESCAPE;
      cfg_r.stuff_mask   <= ifr_pkg::RST_STUFFMASK;
      cfg_r.ctrl_seq0    <= ifr_pkg::RST_CTRLSEQ0;
      cfg_r.ctrl_seq1    <= ifr_pkg::RST_CTRLSEQ1;
    end else if (cfg_we) begin
      case (cfg_index)
        ifr_pkg::CFG_FLAG:      cfg_r.flag_byte    <= cfg_wdata;
        ifr_pkg::CFG_ADDRESS:   cfg_r.address_byte <= cfg_wdata;
        ifr_pkg::CFG_ESCAPE:    cfg_r.escape_byte  <= cfg_wdata;
        ifr_pkg::CFG_STUFFMASK: cfg_r.stuff_mask   <= cfg_wdata;
        ifr_pkg::CFG_CTRLSEQ0:  cfg_r.ctrl_seq0    <= cfg_wdata;
        ifr_pkg::CFG_CTRLSEQ1:  cfg_r.ctrl_seq1    <= cfg_wdata;
        default: ;
      endcase
    end
  end

  assign cfg_o = cfg_r;

endmodule

`default_nettype wire

FILE: design/ifr_parser.sv
// ----------------------------------------------------------------------------
// ifr_parser
// Per-byte frame parser: header checks, destuffing, held byte and XOR check.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "info_frame_receiver_defines.svh"

module ifr_parser (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire ifr_pkg::cfg_t cfg_i,
  input  wire logic          fire_i,
  input  wire logic [7:0]    rx_byte_i,
  output logic               res_valid_o,
  output ifr_pkg::res_t      res_o
);

  typedef enum logic [2:0] {
    PH_HUNT = 3'd0,
    PH_ADDR = 3'd1,
    PH_CTRL = 3'd2,
    PH_HCHK = 3'd3,
    PH_DATA = 3'd4
  } phase_t;

  phase_t     phase_r, phase_nxt;
  logic       rseq_r, rseq_nxt;
  logic       eseq_r, eseq_nxt;
  logic       esc_pend_r, esc_pend_nxt;
  logic [7:0] held_r, held_nxt;
  logic       held_v_r, held_v_nxt;
  logic [7:0] xor_r, xor_nxt;
  logic       esc_err_r, esc_err_nxt;

  always_comb begin
    logic       have;
    logic [7:0] decoded;
    logic [7:0] ctrl_sel;

    have         = 1'b0;
    decoded      = 8'h00;
    ctrl_sel     = rseq_r ? cfg_i.ctrl_seq1 : cfg_i.ctrl_seq0;
    phase_nxt    = phase_r;
    rseq_nxt     = rseq_r;
    eseq_nxt     = eseq_r;
    esc_pend_nxt = esc_pend_r;
    held_nxt     = held_r;
    held_v_nxt   = held_v_r;
    xor_nxt      = xor_r;
    esc_err_nxt  = esc_err_r;
    res_valid_o  = 1'b0;
    res_o        = '0;

    if (fire_i) begin
      case (phase_r)
        PH_ADDR: begin
          if (rx_byte_i == cfg_i.address_byte) begin
            phase_nxt = PH_CTRL;
          end else if (rx_byte_i != cfg_i.flag_byte) begin
            phase_nxt = PH_HUNT;
          end
        end
        PH_CTRL: begin
          // Equal control registers resolve to sequence 0.
          if (rx_byte_i == cfg_i.ctrl_seq0) begin
            rseq_nxt  = 1'b0;
            phase_nxt = PH_HCHK;
          end else if (rx_byte_i == cfg_i.ctrl_seq1) begin
            rseq_nxt  = 1'b1;
            phase_nxt = PH_HCHK;
          end else if (rx_byte_i == cfg_i.flag_byte) begin
            phase_nxt = PH_ADDR;
          end else begin
            phase_nxt = PH_HUNT;
          end
        end
        PH_HCHK: begin
          if (rx_byte_i == (ctrl_sel ^ cfg_i.address_byte)) begin
            phase_nxt    = PH_DATA;
            esc_pend_nxt = 1'b0;
            held_v_nxt   = 1'b0;
            held_nxt     = 8'h00;
            xor_nxt      = 8'h00;
            esc_err_nxt  = 1'b0;
          end else if (rx_byte_i == cfg_i.flag_byte) begin
            phase_nxt = PH_ADDR;
          end else begin
            phase_nxt          = PH_HUNT;
            res_valid_o        = 1'b1;
            res_o.out_kind     = ifr_pkg::KIND_REJECT;
            res_o.reply_kind   = ifr_pkg::REPLY_REJECT;
            res_o.reply_seq    = ~rseq_r;
          end
        end
        PH_DATA: begin
          if (rx_byte_i == cfg_i.flag_byte) begin
            phase_nxt      = PH_HUNT;
            res_valid_o    = 1'b1;
            res_o.out_kind = ifr_pkg::KIND_STATUS;
            if (esc_err_r || esc_pend_r || !held_v_r || (xor_r != held_r)) begin
              res_o.frame_status = ifr_pkg::ST_CHECK_ERR;
              res_o.reply_kind   = ifr_pkg::REPLY_REJECT;
              res_o.reply_seq    = ~rseq_r;
            end else if (rseq_r == eseq_r) begin
              res_o.frame_status = ifr_pkg::ST_ACCEPTED;
              res_o.reply_kind   = ifr_pkg::REPLY_READY;
              res_o.reply_seq    = ~eseq_r;
              eseq_nxt           = ~eseq_r;
            end else begin
              res_o.frame_status = ifr_pkg::ST_DUPLICATE;
              res_o.reply_kind   = ifr_pkg::REPLY_READY;
              res_o.reply_seq    = ~eseq_r;
            end
            esc_pend_nxt = 1'b0;
            held_v_nxt   = 1'b0;
          end else begin
            if (esc_pend_r) begin
              esc_pend_nxt = 1'b0;
              if (rx_byte_i == (cfg_i.flag_byte ^ cfg_i.stuff_mask)) begin
                decoded = cfg_i.flag_byte;
                have    = 1'b1;
              end else if (rx_byte_i == (cfg_i.escape_byte ^ cfg_i.stuff_mask)) begin
                decoded = cfg_i.escape_byte;
                have    = 1'b1;
              end else begin
                esc_err_nxt = 1'b1;
              end
            end else if (rx_byte_i == cfg_i.escape_byte) begin
              esc_pend_nxt = 1'b1;
            end else begin
              decoded = rx_byte_i;
              have    = 1'b1;
            end
            // One decoded byte is always held back so the check byte is
            // never delivered.
            if (have) begin
              held_nxt   = decoded;
              held_v_nxt = 1'b1;
              if (held_v_r) begin
                xor_nxt            = xor_r ^ held_r;
                res_valid_o        = 1'b1;
                res_o.out_kind     = ifr_pkg::KIND_PAYLOAD;
                res_o.payload_byte = held_r;
              end
            end
          end
        end
        default: begin
          phase_nxt = (rx_byte_i == cfg_i.flag_byte) ? PH_ADDR : PH_HUNT;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r    <= PH_HUNT;
      rseq_r     <= 1'b0;
      eseq_r     <= 1'b0;
      esc_pend_r <= 1'b0;
      held_r     <= 8'h00;
      held_v_r   <= 1'b0;
      xor_r      <= 8'h00;
      esc_err_r  <= 1'b0;
    end else begin
      phase_r    <= phase_nxt;
      rseq_r     <= rseq_nxt;
      eseq_r     <= eseq_nxt;
      esc_pend_r <= esc_pend_nxt;
      held_r     <= held_nxt;
      held_v_r   <= held_v_nxt;
      xor_r      <= xor_nxt;
      esc_err_r  <= esc_err_nxt;
    end
  end

  `IFR_ASSERT_NEXT(a_close_clears, clk, rst_n,
    fire_i && (phase_r == PH_DATA) && (rx_byte_i == cfg_i.flag_byte),
    (phase_r == PH_HUNT) && !held_v_r && !esc_pend_r)
  `IFR_ASSERT_NEXT(a_accept_toggles, clk, rst_n,
    res_valid_o && (res_o.out_kind == ifr_pkg::KIND_STATUS) &&
    (res_o.frame_status == ifr_pkg::ST_ACCEPTED),
    eseq_r != $past(eseq_r))
  `IFR_ASSERT_NOW(a_payload_from_data, clk, rst_n,
    res_valid_o && (res_o.out_kind == ifr_pkg::KIND_PAYLOAD),
    (phase_r == PH_DATA) && held_v_r)

endmodule

`default_nettype wire

FILE: design/ifr_out_stage.sv
// ----------------------------------------------------------------------------
// ifr_out_stage
// Result register with a skid entry that decouples the two handshakes.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module ifr_out_stage (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          push_i,
  input  wire ifr_pkg::res_t push_data_i,
  output logic               space_o,
  output logic               out_valid_o,
  input  wire logic          out_ready_i,
  output ifr_pkg::res_t      out_data_o
);

  logic          main_v_r, main_v_nxt;
  logic          skid_v_r, skid_v_nxt;
  ifr_pkg::res_t main_r, main_nxt;
  ifr_pkg::res_t skid_r, skid_nxt;
  logic          pop;

  assign pop     = main_v_r && out_ready_i;
  assign space_o = !skid_v_r;

  always_comb begin
    main_v_nxt = main_v_r;
    skid_v_nxt = skid_v_r;
    main_nxt   = main_r;
    skid_nxt   = skid_r;
    if (skid_v_r) begin
      if (pop) begin
        main_nxt   = skid_r;
        skid_v_nxt = 1'b0;
      end
    end else if (push_i) begin
      if (!main_v_r || pop) begin
        main_nxt   = push_data_i;
        main_v_nxt = 1'b1;
      end else begin
        skid_nxt   = push_data_i;
        skid_v_nxt = 1'b1;
      end
    end else if (pop) begin
      main_v_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      main_v_r <= 1'b0;
      skid_v_r <= 1'b0;
    end else begin
      main_v_r <= main_v_nxt;
      skid_v_r <= skid_v_nxt;
    end
    main_r <= main_nxt;
    skid_r <= skid_nxt;
  end

  assign out_valid_o = main_v_r;
  assign out_data_o  = main_r;

endmodule

`default_nettype wire

FILE: design/info_frame_receiver.sv
// ----------------------------------------------------------------------------
// info_frame_receiver
// Receive side of a stop-and-wait, HDLC-style information frame link.
// ----------------------------------------------------------------------------
// Usage:
//   Line bytes enter one per request on in_rx (payload field rx_byte). Each
//   byte yields zero or one result request on out_res: a destuffed payload
//   byte, a frame end status with the reply to send, or a header reject.
//   The trailing check byte of a frame is never delivered as payload.
//   Each result is registered in the result register, or in the skid entry
//   when that one is full. Throughput: one byte per cycle while the skid
//   entry is free, set by the single pass through the parser.
//   Stalls: a result register plus one skid entry sit after the parser; the
//   input keeps taking bytes while one result waits, and in_rx.ready drops
//   only when both entries are full, so nothing is lost or repeated.
//   Reset (rst_n low, synchronous): the configuration registers return to
//   their defaults, the parser hunts for an opening flag, the expected
//   sequence is zero and both result entries are emptied.
//   Configuration: cfg_we writes cfg_wdata to register cfg_index (flag,
//   address, escape, stuff mask, control for sequence 0 and 1); write only
//   while no bytes are in flight.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module info_frame_receiver (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        cfg_we,
  input  wire logic [ifr_pkg::CfgIdxW-1:0] cfg_index,
  input  wire logic [7:0]                  cfg_wdata,
  ifr_stream_if.sink                       in_rx,
  ifr_stream_if.source                     out_res
);

  ifr_pkg::cfg_t    cfg;
  ifr_pkg::in_item_t in_item;
  ifr_pkg::res_t    res;
  ifr_pkg::res_t    out_data;
  logic             res_valid;
  logic             space;
  logic             fire;

  // A byte is taken whenever the skid entry is free.
  assign in_rx.ready = space;
  assign fire        = in_rx.valid && space;
  assign in_item     = in_rx.payload;

  ifr_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg_o     (cfg)
  );

  ifr_parser u_parser (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_i       (cfg),
    .fire_i      (fire),
    .rx_byte_i   (in_item.rx_byte),
    .res_valid_o (res_valid),
    .res_o       (res)
  );

  ifr_out_stage u_out (
    .clk         (clk),
    .rst_n       (rst_n),
    .push_i      (res_valid),
    .push_data_i (res),
    .space_o     (space),
    .out_valid_o (out_res.valid),
    .out_ready_i (out_res.ready),
    .out_data_o  (out_data)
  );

  assign out_res.payload = out_data;

endmodule

`default_nettype wire
